// ===== rtl/wpsc_pkg.sv =====
// Package for the sliding window product counter.
// Holds field widths, saturation limits and the controller/datapath command
// and status structs. No dependencies.
`timescale 1ns / 1ps

package wpsc_pkg;

    localparam int VAL_W = 10;
    localparam int THR_W = 20;
    localparam int NEW_W = 11;
    localparam int TOT_W = 20;
    localparam int PRD_W = THR_W + VAL_W;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [NEW_W-1:0] NEW_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // restoring divider: one quotient bit per cycle over the THR_W-bit running product
    localparam int DIV_STEPS = THR_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;        // latch accepted beat, update sequence length
        logic mul;         // register product * value
        logic clear_win;   // empty the window
        logic div_start;   // load divider
        logic div_step;    // one quotient bit
        logic drop;        // retire front element with quotient
        logic append;      // write element, grow window
        logic finish;      // update totals and load output register
    } wpsc_cmd_t;

    typedef struct packed {
        logic bypass;      // value zero or not below threshold
        logic drop_needed; // window must shrink before the append
        logic div_last;    // final divider step
        logic out_free;    // output register can take a result
    } wpsc_sts_t;

endpackage

// ===== rtl/wpsc_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module wpsc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/wpsc_ctrl.sv =====
// Controller state machine for the window product counter.
// Depends on wpsc_pkg for the command and status structs.
`timescale 1ns / 1ps

module wpsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wpsc_pkg::wpsc_sts_t sts,
    output wpsc_pkg::wpsc_cmd_t cmd
);
    import wpsc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DROP   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // sequence the per-beat work
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (sts.bypass)
                begin
                    cmd.clear_win = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mul = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.drop_needed)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    cmd.append = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                // wait for the registered read of the front element
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                cmd.drop = 1'b1;
                state_next = S_MUL;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/wpsc_dp.sv =====
// Datapath for the window product counter: window ring, product, divider,
// counters and output register. Depends on wpsc_pkg and wpsc_ram.
`timescale 1ns / 1ps

module wpsc_dp #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wpsc_pkg::THR_W-1:0]   cfg_wdata,
    input  logic [wpsc_pkg::VAL_W-1:0]   in_value,
    input  logic                         in_last,
    input  wpsc_pkg::wpsc_cmd_t          cmd,
    output wpsc_pkg::wpsc_sts_t          sts,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [wpsc_pkg::NEW_W-1:0]   out_new,
    output logic [wpsc_pkg::TOT_W-1:0]   out_total,
    output logic                         out_last,
    output logic                         out_ovf
);
    import wpsc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int SEQ_W = $clog2(MAX_LEN + 2);
    localparam int SUM_W = LEN_W + 1;

    logic [THR_W-1:0]  thr_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              last_reg;
    logic [THR_W-1:0]  prod_reg;
    logic [PRD_W-1:0]  pv_reg;
    logic [AW-1:0]     front_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              ovf_reg;
    logic [THR_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [VAL_W-1:0]  rd_data;
    logic [SUM_W-1:0]  back_sum;
    logic [AW-1:0]     back_addr;
    logic [AW-1:0]     front_inc;
    logic [VAL_W:0]    div_sh;
    logic              div_ge;
    logic [SEQ_W-1:0]  seq_inc;
    logic [NEW_W-1:0]  new_sat;
    logic [TOT_W:0]    tot_sum;
    logic [TOT_W-1:0]  tot_sat;

    // ring addresses
    always_comb
    begin
        back_sum = SUM_W'(front_reg) + SUM_W'(len_reg);
        if (back_sum >= SUM_W'(MAX_LEN))
        begin
            back_sum = back_sum - SUM_W'(MAX_LEN);
        end
        back_addr = back_sum[AW-1:0];
        front_inc = (front_reg == AW'(MAX_LEN - 1)) ? '0 : front_reg + 1'b1;
    end

    wpsc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (back_addr),
        .wdata (val_reg),
        .raddr (front_reg),
        .rdata (rd_data)
    );

    // status toward the controller
    always_comb
    begin
        sts.bypass = (val_reg == '0) || (THR_W'(val_reg) >= thr_reg);
        sts.drop_needed = ((len_reg != '0) && (pv_reg >= PRD_W'(thr_reg)))
                          || (len_reg == LEN_W'(MAX_LEN));
        sts.div_last = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
        sts.out_free = !out_valid || out_ready;
    end

    // divider step, counts and saturation
    always_comb
    begin
        div_sh = {rem_reg, quo_reg[THR_W-1]};
        div_ge = (div_sh >= {1'b0, dvs_reg});
        seq_inc = (seq_reg <= SEQ_W'(MAX_LEN)) ? seq_reg + 1'b1 : seq_reg;
        if (32'(len_reg) > 32'(NEW_MAX))
        begin
            new_sat = NEW_MAX;
        end
        else
        begin
            new_sat = NEW_W'(len_reg);
        end
        tot_sum = {1'b0, total_reg} + (TOT_W + 1)'(new_sat);
        tot_sat = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
    end

    // hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // payload registers: beat, multiply, divider
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= in_value;
            last_reg <= in_last;
        end
        if (cmd.mul)
        begin
            pv_reg <= prod_reg * val_reg;
        end
        if (cmd.div_start)
        begin
            dvs_reg <= (rd_data == '0) ? VAL_W'(1) : rd_data;
            rem_reg <= '0;
            quo_reg <= prod_reg;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? VAL_W'(div_sh - {1'b0, dvs_reg}) : div_sh[VAL_W-1:0];
            quo_reg <= {quo_reg[THR_W-2:0], div_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            out_new <= new_sat;
            out_total <= tot_sat;
            out_last <= last_reg;
            out_ovf <= ovf_reg;
        end
    end

    // window and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= THR_W'(1);
            front_reg <= '0;
            len_reg <= '0;
            seq_reg <= '0;
            total_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.load)
            begin
                seq_reg <= seq_inc;
                if (seq_inc > SEQ_W'(MAX_LEN))
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear_win)
            begin
                prod_reg <= THR_W'(1);
                front_reg <= '0;
                len_reg <= '0;
            end
            if (cmd.drop)
            begin
                front_reg <= front_inc;
                len_reg <= len_reg - 1'b1;
                prod_reg <= (len_reg == LEN_W'(1)) ? THR_W'(1) : quo_reg;
            end
            if (cmd.append)
            begin
                len_reg <= len_reg + 1'b1;
                prod_reg <= pv_reg[THR_W-1:0];
            end
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
                if (last_reg)
                begin
                    prod_reg <= THR_W'(1);
                    front_reg <= '0;
                    len_reg <= '0;
                    seq_reg <= '0;
                    total_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    total_reg <= tot_sat;
                end
            end
        end
    end

endmodule

// ===== rtl/window_product_subarray_counter.sv =====
// Sliding window product counter, top level.
// Each input beat is loaded, then multiplied into the window and appended, or clears the
// window when it bypasses (zero or not below threshold); each front element dropped adds
// a memory read, a 20-step restoring divider, the drop and a new multiply.
// A new beat is accepted only after the previous result is loaded into the output register,
// so the shared divider never overlaps beats; a stalled result holds the input off.
// Reset (rst_n, async low) empties the window, clears counts and threshold.
`timescale 1ns / 1ps

module window_product_subarray_counter #(
    parameter int MAX_LEN = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,        // threshold
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,     // [9:0] value, [15:10] zero
    input  logic        s_axis_tlast,     // seq_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,     // [10:0] new_count, [30:11] running_total,
                                          // [31] overflow
    output logic        m_axis_tlast      // is_last
);
    import wpsc_pkg::*;

    wpsc_cmd_t        cmd;
    wpsc_sts_t        sts;
    logic [NEW_W-1:0] out_new;
    logic [TOT_W-1:0] out_total;
    logic             out_ovf;

    wpsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpsc_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_value  (s_axis_tdata[VAL_W-1:0]),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_new   (out_new),
        .out_total (out_total),
        .out_last  (m_axis_tlast),
        .out_ovf   (out_ovf)
    );

    assign m_axis_tdata = {out_ovf, out_total, out_new};

endmodule
